// ----- rtl/core/piecewise_linear_evaluator_defines.svh -----
// Assertion macros of the piecewise linear evaluator RTL, used by ple_locate.
`ifndef PIECEWISE_LINEAR_EVALUATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_EVALUATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check that is switched off while reset is asserted.
`define PLE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
// Clocked check that also holds during reset.
`define PLE_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PLE_ASSERT(lbl, clk, rst_n, prop)
`define PLE_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- rtl/core/ple_pkg.sv -----
// Shared types, codes and sizes of the piecewise linear evaluator.
`default_nettype none
package ple_pkg;
	localparam int MAX_POINTS = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int DATA_W     = 32;
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = DATA_W / DIV_STEP;

	// Request codes; the spare code is ignored by the block.
	localparam logic [1:0] REQ_EVAL   = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;
	localparam logic [1:0] REQ_RSVD   = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_NO_SEG = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef enum logic [1:0] {
		MODE_ZERO,
		MODE_CONST,
		MODE_SEG
	} mode_t;

	typedef struct packed {
		logic [1:0]               req_type;
		logic signed [DATA_W-1:0] x_value;
		logic signed [DATA_W-1:0] y_value;
	} ple_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] y_result;
		logic [1:0]               status;
	} ple_out_t;

	typedef struct packed {
		logic       valid;
		mode_t      mode;
		logic [1:0] status;
	} ple_ctl_t;

	// Control and operands that ride alongside the product through the divider.
	typedef struct packed {
		ple_ctl_t                 ctl;
		logic                     neg;
		logic signed [DATA_W-1:0] y0;
		logic [DATA_W-1:0]        divisor;
	} ple_arith_t;
endpackage
`default_nettype wire

// ----- rtl/core/ple_locate.sv -----
// Breakpoint table, segment search and table row reads.
`default_nettype none
`include "piecewise_linear_evaluator_defines.svh"
module ple_locate import ple_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     adv,
	input  wire logic                     in_valid,
	input  wire ple_in_t                  in_data,
	output ple_ctl_t                      ctl_s2,
	output logic signed [DATA_W-1:0]      x_s2,
	output logic [2*DATA_W-1:0]           row_a_s2,
	output logic [2*DATA_W-1:0]           row_b_s2
);
	logic                     v_s1;
	ple_in_t                  item_s1;
	logic [CNT_W-1:0]         count_q;
	logic signed [DATA_W-1:0] bx_q [MAX_POINTS];
	logic [2*DATA_W-1:0]      pt_mem [MAX_POINTS];

	logic [MAX_POINTS-1:0]    in_tab, ge, le;
	logic [MAX_POINTS-2:0]    hit;
	logic                     found;
	logic [IDX_W-1:0]         seg_idx, last_idx, addr_a, addr_b;
	logic [CNT_W-1:0]         last_cnt;
	logic                     wr_en;
	ple_ctl_t                 ctl_d;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= in_data;
		end
	end

	// Compare lanes, one per stored breakpoint.
	always_comb begin
		for (int j = 0; j < MAX_POINTS; j++) begin
			in_tab[j] = CNT_W'(j) < count_q;
			ge[j]     = item_s1.x_value >= bx_q[j];
			le[j]     = item_s1.x_value <= bx_q[j];
		end
		for (int j = 0; j < MAX_POINTS - 1; j++) begin
			hit[j] = in_tab[j+1] & ge[j] & le[j+1];
		end
	end

	// The first matching segment wins.
	always_comb begin
		found   = 1'b0;
		seg_idx = '0;
		for (int j = MAX_POINTS - 2; j >= 0; j--) begin
			if (hit[j]) begin
				found   = 1'b1;
				seg_idx = IDX_W'(j);
			end
		end
	end

	assign last_cnt = count_q - CNT_W'(1);
	assign last_idx = last_cnt[IDX_W-1:0];
	assign addr_b   = seg_idx + IDX_W'(1);
	assign wr_en    = adv && v_s1 && item_s1.req_type == REQ_APPEND
	                  && count_q < CNT_W'(MAX_POINTS);

	// Sort the item into a result kind and choose the row to read.
	always_comb begin
		ctl_d.valid  = v_s1;
		ctl_d.mode   = MODE_ZERO;
		ctl_d.status = ST_OK;
		addr_a       = '0;
		if (item_s1.req_type == REQ_EVAL) begin
			if (count_q == '0) begin
				ctl_d.status = ST_EMPTY;
			end else if (!ge[0] || (count_q == CNT_W'(1) && le[0])) begin
				ctl_d.mode = MODE_CONST;
			end else if (!le[last_idx]) begin
				ctl_d.mode = MODE_CONST;
				addr_a     = last_idx;
			end else if (found) begin
				ctl_d.mode = MODE_SEG;
				addr_a     = seg_idx;
			end else begin
				ctl_d.status = ST_NO_SEG;
			end
		end else if (item_s1.req_type == REQ_APPEND
		             && count_q >= CNT_W'(MAX_POINTS)) begin
			ctl_d.status = ST_FULL;
		end
	end

	// Point count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (adv && v_s1) begin
			if (item_s1.req_type == REQ_CLEAR) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Breakpoint x lanes.
	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_POINTS; j++) begin
			if (wr_en && count_q == CNT_W'(j)) begin
				bx_q[j] <= item_s1.x_value;
			end
		end
	end

	// Point memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pt_mem[count_q[IDX_W-1:0]] <= {item_s1.x_value, item_s1.y_value};
		end
		if (adv) begin
			row_a_s2 <= pt_mem[addr_a];
			row_b_s2 <= pt_mem[addr_b];
		end
	end

	// Second stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2 <= item_s1.x_value;
		end
	end

	`PLE_ASSERT(a_count_range, clk, arst_n, count_q <= CNT_W'(MAX_POINTS))
	`PLE_ASSERT(a_clear_empties, clk, arst_n, adv && v_s1 && item_s1.req_type == REQ_CLEAR |=> count_q == '0)
	`PLE_ASSERT(a_append_counts, clk, arst_n, wr_en |=> count_q == $past(count_q) + CNT_W'(1))
endmodule
`default_nettype wire

// ----- rtl/core/ple_slope.sv -----
// Segment differences and the wide product of offset and rise.
`default_nettype none
module ple_slope import ple_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     adv,
	input  wire ple_ctl_t                 ctl_s2,
	input  wire logic signed [DATA_W-1:0] x_s2,
	input  wire logic [2*DATA_W-1:0]      row_a_s2,
	input  wire logic [2*DATA_W-1:0]      row_b_s2,
	output ple_arith_t                    arith_s4,
	output logic [2*DATA_W-1:0]           prod_s4
);
	logic signed [DATA_W-1:0] x0, y0, x1, y1;
	logic signed [DATA_W:0]   dx, dy, dt, ady;
	ple_arith_t               arith_d, arith_s3;
	logic [DATA_W-1:0]        dt_s3, ady_s3;

	assign x0 = row_a_s2[2*DATA_W-1:DATA_W];
	assign y0 = row_a_s2[DATA_W-1:0];
	assign x1 = row_b_s2[2*DATA_W-1:DATA_W];
	assign y1 = row_b_s2[DATA_W-1:0];

	// Differences at one bit more than the operands.
	always_comb begin
		dx  = {x1[DATA_W-1], x1} - {x0[DATA_W-1], x0};
		dy  = {y1[DATA_W-1], y1} - {y0[DATA_W-1], y0};
		dt  = {x_s2[DATA_W-1], x_s2} - {x0[DATA_W-1], x0};
		ady = dy[DATA_W] ? -dy : dy;
		arith_d.ctl     = ctl_s2;
		arith_d.neg     = dy[DATA_W];
		arith_d.y0      = y0;
		arith_d.divisor = dx[DATA_W-1:0];
		// A segment of zero width yields its left ordinate.
		if (ctl_s2.mode == MODE_SEG && dx == '0) begin
			arith_d.ctl.mode = MODE_CONST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arith_s3 <= '0;
			arith_s4 <= '0;
		end else if (adv) begin
			arith_s3 <= arith_d;
			arith_s4 <= arith_s3;
		end
	end

	// Operand and product registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			dt_s3   <= dt[DATA_W-1:0];
			ady_s3  <= ady[DATA_W-1:0];
			prod_s4 <= dt_s3 * ady_s3;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/ple_divider.sv -----
// Pipelined restoring divider, four quotient bits per stage.
`default_nettype none
module ple_divider import ple_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire ple_arith_t          arith_s4,
	input  wire logic [2*DATA_W-1:0] prod_s4,
	output ple_arith_t               arith_out,
	output logic [DATA_W-1:0]        quot_out
);
	ple_arith_t        arith_sn [DIV_STAGES];
	logic [DATA_W-1:0] rem_sn   [DIV_STAGES];
	logic [DATA_W-1:0] lo_sn    [DIV_STAGES];
	logic [DATA_W-1:0] quot_sn  [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		ple_arith_t        arith_in;
		logic [DATA_W-1:0] rem_in, lo_in, quot_in;
		logic [DATA_W-1:0] rem_d, lo_d, quot_d;

		if (k == 0) begin : g_first
			// The quotient fits the word, so the upper half is already below the divisor.
			assign arith_in = arith_s4;
			assign rem_in   = prod_s4[2*DATA_W-1:DATA_W];
			assign lo_in    = prod_s4[DATA_W-1:0];
			assign quot_in  = '0;
		end else begin : g_next
			assign arith_in = arith_sn[k-1];
			assign rem_in   = rem_sn[k-1];
			assign lo_in    = lo_sn[k-1];
			assign quot_in  = quot_sn[k-1];
		end

		// Shift in one dividend bit and try a subtraction, several times.
		always_comb begin
			logic [DATA_W:0] trial;
			rem_d  = rem_in;
			lo_d   = lo_in;
			quot_d = quot_in;
			for (int b = 0; b < DIV_STEP; b++) begin
				trial = {rem_d, lo_d[DATA_W-1]};
				lo_d  = {lo_d[DATA_W-2:0], 1'b0};
				if (trial >= {1'b0, arith_in.divisor}) begin
					trial  = trial - {1'b0, arith_in.divisor};
					quot_d = {quot_d[DATA_W-2:0], 1'b1};
				end else begin
					quot_d = {quot_d[DATA_W-2:0], 1'b0};
				end
				rem_d = trial[DATA_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				arith_sn[k] <= '0;
			end else if (adv) begin
				arith_sn[k] <= arith_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sn[k]  <= rem_d;
				lo_sn[k]   <= lo_d;
				quot_sn[k] <= quot_d;
			end
		end
	end

	assign arith_out = arith_sn[DIV_STAGES-1];
	assign quot_out  = quot_sn[DIV_STAGES-1];
endmodule
`default_nettype wire

// ----- rtl/core/piecewise_linear_evaluator.sv -----
// Piecewise linear evaluator over a breakpoint table, top level.
//
// Requests arrive on the req channel (req_valid, req_stall, req) and each
// gives exactly one response on the rsp channel (rsp_valid, rsp_stall, rsp).
// A request evaluates the curve at x, appends a breakpoint or clears the
// table; appends and clears answer with a zero value and their status.
// The pipeline takes one request per cycle while req_stall is low. A response
// passes through table search and row read, segment
// differences, the 32 by 32 multiply, eight divider stages of four quotient
// bits each, and the final scaling with saturation.
// Table updates take effect in the search stage, in request order, so an
// evaluation sees every append and clear that came before it.
// Reset empties the table and drops all requests in flight.
// While the receiver stalls a waiting response, the whole pipeline holds
// and req_stall is raised; nothing is lost or repeated.
`default_nettype none
module piecewise_linear_evaluator import ple_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_stall,
	input  wire ple_in_t req,
	output logic         rsp_valid,
	input  wire logic    rsp_stall,
	output ple_out_t     rsp
);
	logic                     adv;
	ple_ctl_t                 ctl_s2;
	logic signed [DATA_W-1:0] x_s2;
	logic [2*DATA_W-1:0]      row_a_s2, row_b_s2;
	ple_arith_t               arith_s4, arith_dv;
	logic [2*DATA_W-1:0]      prod_s4;
	logic [DATA_W-1:0]        quot_dv;
	logic signed [DATA_W+1:0] step, sum;
	ple_out_t                 out_d;
	logic                     out_valid_q;

	// The pipeline moves unless a finished response is held by the receiver.
	assign adv       = !out_valid_q || !rsp_stall;
	assign req_stall = !adv;
	assign rsp_valid = out_valid_q;

	ple_locate u_locate (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (req_valid),
		.in_data  (req),
		.ctl_s2   (ctl_s2),
		.x_s2     (x_s2),
		.row_a_s2 (row_a_s2),
		.row_b_s2 (row_b_s2)
	);

	ple_slope u_slope (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl_s2   (ctl_s2),
		.x_s2     (x_s2),
		.row_a_s2 (row_a_s2),
		.row_b_s2 (row_b_s2),
		.arith_s4 (arith_s4),
		.prod_s4  (prod_s4)
	);

	ple_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.arith_s4  (arith_s4),
		.prod_s4   (prod_s4),
		.arith_out (arith_dv),
		.quot_out  (quot_dv)
	);

	// Apply the sign of the rise, add the left ordinate and saturate.
	always_comb begin
		step = $signed({2'b00, quot_dv});
		if (arith_dv.neg) begin
			step = -step;
		end
		sum = $signed({{2{arith_dv.y0[DATA_W-1]}}, arith_dv.y0}) + step;
		out_d.status = arith_dv.ctl.status;
		case (arith_dv.ctl.mode)
			MODE_CONST: out_d.y_result = arith_dv.y0;
			MODE_SEG: begin
				if (sum > 34'sd2147483647) begin
					out_d.y_result = 32'sh7FFF_FFFF;
				end else if (sum < -34'sd2147483648) begin
					out_d.y_result = 32'sh8000_0000;
				end else begin
					out_d.y_result = sum[DATA_W-1:0];
				end
			end
			default: out_d.y_result = '0;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= arith_dv.ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp <= out_d;
		end
	end
endmodule
`default_nettype wire
